@@ sv/arl_pkg.sv @@
// shared types and constants for the adaptive rate linear resampler
`default_nettype none

package arl_pkg;

   localparam int PHASE_BITS = 32;
   localparam int STEP_W     = PHASE_BITS + 1;
   localparam int SAMPLE_W   = 16;
   localparam int FRAME_W    = 2 * SAMPLE_W;
   localparam int OUT_W      = 24;
   localparam int FILL_W     = 11;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = FRAME_W;
   localparam int RSP_DATA_W = 96;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_PULL = 1'b1;

   localparam logic [2:0] REG_TARGET_FILL     = 3'd0;
   localparam logic [2:0] REG_START_FILL      = 3'd1;
   localparam logic [2:0] REG_UPDATE_INTERVAL = 3'd2;
   localparam logic [2:0] REG_RATIO_GAIN      = 3'd3;
   localparam logic [2:0] REG_MAX_DEVIATION   = 3'd4;

   localparam logic [10:0] TARGET_FILL_RST     = 11'd512;
   localparam logic [10:0] START_FILL_RST      = 11'd256;
   localparam logic [15:0] UPDATE_INTERVAL_RST = 16'd48;
   localparam logic [15:0] RATIO_GAIN_RST      = 16'd4295;
   localparam logic [30:0] MAX_DEVIATION_RST   = 31'd4294967;

   typedef struct packed {
      logic [10:0] target_fill;
      logic [10:0] start_fill;
      logic [15:0] update_interval;
      logic [15:0] ratio_gain;
      logic [30:0] max_deviation;
   } cfg_type;

   typedef struct packed {
      logic              out_valid;
      logic [OUT_W-1:0]  left_sample;
      logic [OUT_W-1:0]  right_sample;
      logic              starved;
      logic              push_dropped;
      logic [FILL_W-1:0] fill_level;
      logic [STEP_W-1:0] ratio_step;
   } res_type;

endpackage

`default_nettype wire

@@ sv/adaptive_rate_linear_resampler.sv @@
// top level of the adaptive rate linear resampler
//
// channel  direction  handshake                  payload
// req      in         req_tvalid / req_tready    tuser operation, tdata in_left, in_right
// rsp      out        rsp_tvalid / rsp_tready    tuser out_valid, tdata result fields
// csr      in         apb psel/penable/pwrite    five registers at byte address 4*i
//
// a transaction waits in the input holding register, then a push is handled in idle
// and a pull steps through store read, ratio and interpolation multiply, and finish,
// set by the registered frame store read and the multiply stage; preload adds none
// reset is synchronous and active high; no clearing pass, store entries are
// undefined until written; a stalled rsp keeps a pull waiting in its finish state
// and a push in the holding register, which then holds off req
`default_nettype none

module adaptive_rate_linear_resampler #(
   parameter int FIFO_DEPTH = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // in_left, in_right
   input  logic         req_tuser,   // operation
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,   // left_sample, right_sample, starved, push_dropped,
                                     // fill_level, ratio_step, zero pad
   output logic         rsp_tuser,   // out_valid
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import arl_pkg::*;

   localparam int PW = $clog2(FIFO_DEPTH);

   logic                hold_valid_ff, hold_valid_in;
   logic                hold_op_ff;
   logic [FRAME_W-1:0]  hold_frame_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   res_type             rsp_res_ff;
   logic                req_accept;
   logic                out_free;
   logic                take;
   logic                res_valid;
   res_type             res;
   cfg_type             cfg;
   logic                mem_we;
   logic [PW-1:0]       mem_waddr;
   logic [FRAME_W-1:0]  mem_wdata;
   logic                mem_re;
   logic [PW-1:0]       mem_raddr_a;
   logic [PW-1:0]       mem_raddr_b;
   logic [FRAME_W-1:0]  mem_rdata_a;
   logic [FRAME_W-1:0]  mem_rdata_b;

   assign req_tready    = !hold_valid_ff || take;
   assign req_accept    = req_tvalid && req_tready;
   assign hold_valid_in = req_accept || (hold_valid_ff && !take);
   assign out_free      = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in  = res_valid || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      if (req_accept) begin
         hold_op_ff    <= req_tuser;
         // stored frame: left in the upper half
         hold_frame_ff <= {req_tdata[15:0], req_tdata[31:16]};
      end
      if (res_valid) begin
         rsp_res_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_res_ff.out_valid;
   assign rsp_tdata  = {2'b00, rsp_res_ff.ratio_step, rsp_res_ff.fill_level,
                        rsp_res_ff.push_dropped, rsp_res_ff.starved,
                        rsp_res_ff.right_sample, rsp_res_ff.left_sample};

   arl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   arl_frame_store #(
      .DEPTH (FIFO_DEPTH)
   ) u_store (
      .clock     (clock),
      .wr_en     (mem_we),
      .wr_addr   (mem_waddr),
      .wr_data   (mem_wdata),
      .rd_en     (mem_re),
      .rd_addr_a (mem_raddr_a),
      .rd_addr_b (mem_raddr_b),
      .rd_data_a (mem_rdata_a),
      .rd_data_b (mem_rdata_b)
   );

   arl_engine #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .hold_valid  (hold_valid_ff),
      .hold_op     (hold_op_ff),
      .hold_frame  (hold_frame_ff),
      .cfg         (cfg),
      .out_free    (out_free),
      .take        (take),
      .res_valid   (res_valid),
      .res         (res),
      .mem_we      (mem_we),
      .mem_waddr   (mem_waddr),
      .mem_wdata   (mem_wdata),
      .mem_re      (mem_re),
      .mem_raddr_a (mem_raddr_a),
      .mem_raddr_b (mem_raddr_b),
      .mem_rdata_a (mem_rdata_a),
      .mem_rdata_b (mem_rdata_b)
   );

endmodule

`default_nettype wire

@@ sv/arl_csr.sv @@
// configuration register file behind the apb-style port
`default_nettype none

module arl_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [arl_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [arl_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [arl_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   output arl_pkg::cfg_type                cfg
);
   import arl_pkg::*;

   logic [10:0] target_fill_ff;
   logic [10:0] start_fill_ff;
   logic [15:0] update_interval_ff;
   logic [15:0] ratio_gain_ff;
   logic [30:0] max_deviation_ff;
   logic        wr_en;
   logic [2:0]  reg_index;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_fill_ff     <= TARGET_FILL_RST;
         start_fill_ff      <= START_FILL_RST;
         update_interval_ff <= UPDATE_INTERVAL_RST;
         ratio_gain_ff      <= RATIO_GAIN_RST;
         max_deviation_ff   <= MAX_DEVIATION_RST;
      end else if (wr_en) begin
         unique case (reg_index)
            REG_TARGET_FILL:     target_fill_ff     <= csr_pwdata[10:0];
            REG_START_FILL:      start_fill_ff      <= csr_pwdata[10:0];
            REG_UPDATE_INTERVAL: update_interval_ff <= csr_pwdata[15:0];
            REG_RATIO_GAIN:      ratio_gain_ff      <= csr_pwdata[15:0];
            REG_MAX_DEVIATION:   max_deviation_ff   <= csr_pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_TARGET_FILL:     csr_prdata = CSR_DATA_W'(target_fill_ff);
         REG_START_FILL:      csr_prdata = CSR_DATA_W'(start_fill_ff);
         REG_UPDATE_INTERVAL: csr_prdata = CSR_DATA_W'(update_interval_ff);
         REG_RATIO_GAIN:      csr_prdata = CSR_DATA_W'(ratio_gain_ff);
         REG_MAX_DEVIATION:   csr_prdata = CSR_DATA_W'(max_deviation_ff);
         default:             csr_prdata = '0;
      endcase
   end

   assign cfg.target_fill     = target_fill_ff;
   assign cfg.start_fill      = start_fill_ff;
   assign cfg.update_interval = update_interval_ff;
   assign cfg.ratio_gain      = ratio_gain_ff;
   assign cfg.max_deviation   = max_deviation_ff;

endmodule

`default_nettype wire

@@ sv/arl_frame_store.sv @@
// frame fifo storage: one write port, two registered read ports
`default_nettype none

module arl_frame_store #(
   parameter  int DEPTH = 1024,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [AW-1:0]                wr_addr,
   input  logic [arl_pkg::FRAME_W-1:0]  wr_data,
   input  logic                         rd_en,
   input  logic [AW-1:0]                rd_addr_a,
   input  logic [AW-1:0]                rd_addr_b,
   output logic [arl_pkg::FRAME_W-1:0]  rd_data_a,
   output logic [arl_pkg::FRAME_W-1:0]  rd_data_b
);
   import arl_pkg::*;

   logic [FRAME_W-1:0] store_ff [DEPTH];
   logic [FRAME_W-1:0] rd_data_a_ff;
   logic [FRAME_W-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= store_ff[rd_addr_a];
         rd_data_b_ff <= store_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

`default_nettype wire

@@ sv/arl_engine.sv @@
// fifo pointers, rate control and interpolation sequencer around the frame store
`default_nettype none

module arl_engine #(
   parameter  int FIFO_DEPTH = 1024,
   localparam int PW         = $clog2(FIFO_DEPTH)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         hold_valid,
   input  logic                         hold_op,
   input  logic [arl_pkg::FRAME_W-1:0]  hold_frame,
   input  arl_pkg::cfg_type             cfg,
   input  logic                         out_free,
   output logic                         take,
   output logic                         res_valid,
   output arl_pkg::res_type             res,
   output logic                         mem_we,
   output logic [PW-1:0]                mem_waddr,
   output logic [arl_pkg::FRAME_W-1:0]  mem_wdata,
   output logic                         mem_re,
   output logic [PW-1:0]                mem_raddr_a,
   output logic [PW-1:0]                mem_raddr_b,
   input  logic [arl_pkg::FRAME_W-1:0]  mem_rdata_a,
   input  logic [arl_pkg::FRAME_W-1:0]  mem_rdata_b
);
   import arl_pkg::*;

   localparam int CW   = $clog2(FIFO_DEPTH + 1);
   localparam int MW   = (CW > FILL_W) ? CW : FILL_W;
   localparam int EW   = MW + 1;
   localparam int DVW  = EW + 17;
   localparam int CMPW = (DVW > PHASE_BITS) ? DVW : PHASE_BITS;
   localparam int PRW  = SAMPLE_W + 1 + PHASE_BITS + 1;

   typedef enum logic [1:0] {S_IDLE, S_EVAL, S_FINISH} state_type;

   function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
      ptr_next = (p == PW'(FIFO_DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   state_type                   state_ff, state_in;
   logic [PW-1:0]               wp_ff, wp_in;
   logic [PW-1:0]               rp_ff, rp_in;
   logic [CW-1:0]               count_ff, count_in;
   logic                        running_ff, running_in;
   logic [PHASE_BITS-1:0]       phase_ff, phase_in;
   logic [STEP_W-1:0]           step_ff, step_in;
   logic [15:0]                 countdown_ff, countdown_in;
   logic [SAMPLE_W-1:0]         cur_l_ff, cur_l_in, cur_r_ff, cur_r_in;
   logic [SAMPLE_W-1:0]         nxt_l_ff, nxt_l_in, nxt_r_ff, nxt_r_in;
   logic                        ok_ff, ok_in;
   logic                        need_ff, need_in;
   logic signed [DVW-1:0]       dev_ff, dev_in;
   logic [OUT_W-1:0]            prod_l_ff, prod_l_in, prod_r_ff, prod_r_in;

   logic                        start_ok;
   logic [CW-1:0]               cnt_eff;
   logic signed [EW-1:0]        err;
   logic [15:0]                 cd0;
   logic [PW-1:0]               rp_skip2;
   logic [SAMPLE_W-1:0]         eff_cl, eff_cr, eff_nl, eff_nr;
   logic [PHASE_BITS-1:0]       eff_ph;
   logic signed [16:0]          diff_l, diff_r;
   logic signed [PRW-1:0]       prod_l, prod_r;
   logic signed [CMPW-1:0]      dev_w, lim_w, clamped;
   logic [STEP_W-1:0]           step_upd, step_new;
   logic [PHASE_BITS+1:0]       phase_sum;
   logic [1:0]                  carry;

   assign start_ok = !running_ff && (MW'(count_ff) >= MW'(cfg.start_fill))
                     && (count_ff >= CW'(2));
   assign cnt_eff  = start_ok ? count_ff - CW'(2) : count_ff;
   assign err      = $signed({1'b0, MW'(cnt_eff)}) - $signed({1'b0, MW'(cfg.target_fill)});
   assign cd0      = start_ok ? cfg.update_interval : countdown_ff;
   assign rp_skip2 = ptr_next(ptr_next(rp_ff));

   assign eff_cl = start_ok ? mem_rdata_a[FRAME_W-1:SAMPLE_W] : cur_l_ff;
   assign eff_cr = start_ok ? mem_rdata_a[SAMPLE_W-1:0]       : cur_r_ff;
   assign eff_nl = start_ok ? mem_rdata_b[FRAME_W-1:SAMPLE_W] : nxt_l_ff;
   assign eff_nr = start_ok ? mem_rdata_b[SAMPLE_W-1:0]       : nxt_r_ff;
   assign eff_ph = start_ok ? '0 : phase_ff;

   assign diff_l = $signed({eff_nl[SAMPLE_W-1], eff_nl}) - $signed({eff_cl[SAMPLE_W-1], eff_cl});
   assign diff_r = $signed({eff_nr[SAMPLE_W-1], eff_nr}) - $signed({eff_cr[SAMPLE_W-1], eff_cr});
   assign prod_l = diff_l * $signed({1'b0, eff_ph});
   assign prod_r = diff_r * $signed({1'b0, eff_ph});

   // clamp of the fill error term, then unity plus deviation
   assign dev_w   = CMPW'(dev_ff);
   assign lim_w   = $signed(CMPW'({1'b0, cfg.max_deviation}));
   assign clamped = (dev_w > lim_w) ? lim_w : ((dev_w < -lim_w) ? -lim_w : dev_w);
   assign step_upd  = {~clamped[PHASE_BITS-1], clamped[PHASE_BITS-1:0]};
   assign step_new  = need_ff ? step_upd : step_ff;
   assign phase_sum = {2'b00, phase_ff} + {1'b0, step_new};
   assign carry     = phase_sum[PHASE_BITS+1:PHASE_BITS];

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      count_in     = count_ff;
      running_in   = running_ff;
      phase_in     = phase_ff;
      step_in      = step_ff;
      countdown_in = countdown_ff;
      cur_l_in     = cur_l_ff;
      cur_r_in     = cur_r_ff;
      nxt_l_in     = nxt_l_ff;
      nxt_r_in     = nxt_r_ff;
      ok_in        = ok_ff;
      need_in      = need_ff;
      dev_in       = dev_ff;
      prod_l_in    = prod_l_ff;
      prod_r_in    = prod_r_ff;
      take         = 1'b0;
      res_valid    = 1'b0;
      res          = '0;
      mem_we       = 1'b0;
      mem_waddr    = wp_ff;
      mem_wdata    = hold_frame;
      mem_re       = 1'b0;
      mem_raddr_a  = rp_ff;
      mem_raddr_b  = ptr_next(rp_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (hold_valid && hold_op == OP_PULL) begin
               take     = 1'b1;
               mem_re   = 1'b1;
               state_in = S_EVAL;
            end else if (hold_valid && out_free) begin
               take      = 1'b1;
               res_valid = 1'b1;
               if (count_ff == CW'(FIFO_DEPTH)) begin
                  res.push_dropped = 1'b1;
               end else begin
                  mem_we   = 1'b1;
                  wp_in    = ptr_next(wp_ff);
                  count_in = count_ff + CW'(1);
               end
               res.fill_level = FILL_W'(count_in);
               res.ratio_step = step_ff;
            end
         end
         S_EVAL: begin
            ok_in     = running_ff || start_ok;
            need_in   = start_ok || (cd0 == 16'd0);
            dev_in    = $signed({1'b0, cfg.ratio_gain}) * err;
            prod_l_in = prod_l[PHASE_BITS+15:PHASE_BITS-8];
            prod_r_in = prod_r[PHASE_BITS+15:PHASE_BITS-8];
            if (running_ff || start_ok) begin
               countdown_in = ((cd0 == 16'd0) ? cfg.update_interval : cd0) - 16'd1;
            end
            if (start_ok) begin
               // preload current and next, then fetch the two frames behind them
               cur_l_in    = eff_cl;
               cur_r_in    = eff_cr;
               nxt_l_in    = eff_nl;
               nxt_r_in    = eff_nr;
               running_in  = 1'b1;
               phase_in    = '0;
               count_in    = cnt_eff;
               rp_in       = rp_skip2;
               mem_re      = 1'b1;
               mem_raddr_a = rp_skip2;
               mem_raddr_b = ptr_next(rp_skip2);
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               res_valid = 1'b1;
               state_in  = S_IDLE;
               if (ok_ff) begin
                  res.out_valid    = 1'b1;
                  res.left_sample  = {cur_l_ff, 8'h00} + prod_l_ff;
                  res.right_sample = {cur_r_ff, 8'h00} + prod_r_ff;
                  step_in          = step_new;
                  if (carry == 2'd0) begin
                     phase_in = phase_sum[PHASE_BITS-1:0];
                  end else if (count_ff == '0) begin
                     cur_l_in    = nxt_l_ff;
                     cur_r_in    = nxt_r_ff;
                     running_in  = 1'b0;
                     phase_in    = '0;
                     res.starved = 1'b1;
                  end else if (carry == 2'd1) begin
                     cur_l_in = nxt_l_ff;
                     cur_r_in = nxt_r_ff;
                     nxt_l_in = mem_rdata_a[FRAME_W-1:SAMPLE_W];
                     nxt_r_in = mem_rdata_a[SAMPLE_W-1:0];
                     rp_in    = ptr_next(rp_ff);
                     count_in = count_ff - CW'(1);
                     phase_in = phase_sum[PHASE_BITS-1:0];
                  end else if (count_ff == CW'(1)) begin
                     cur_l_in    = mem_rdata_a[FRAME_W-1:SAMPLE_W];
                     cur_r_in    = mem_rdata_a[SAMPLE_W-1:0];
                     nxt_l_in    = mem_rdata_a[FRAME_W-1:SAMPLE_W];
                     nxt_r_in    = mem_rdata_a[SAMPLE_W-1:0];
                     rp_in       = ptr_next(rp_ff);
                     count_in    = '0;
                     running_in  = 1'b0;
                     phase_in    = '0;
                     res.starved = 1'b1;
                  end else begin
                     cur_l_in = mem_rdata_a[FRAME_W-1:SAMPLE_W];
                     cur_r_in = mem_rdata_a[SAMPLE_W-1:0];
                     nxt_l_in = mem_rdata_b[FRAME_W-1:SAMPLE_W];
                     nxt_r_in = mem_rdata_b[SAMPLE_W-1:0];
                     rp_in    = rp_skip2;
                     count_in = count_ff - CW'(2);
                     phase_in = phase_sum[PHASE_BITS-1:0];
                  end
               end
               res.fill_level = FILL_W'(count_in);
               res.ratio_step = step_in;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         count_ff     <= '0;
         running_ff   <= 1'b0;
         phase_ff     <= '0;
         step_ff      <= {1'b1, {PHASE_BITS{1'b0}}};
         countdown_ff <= '0;
         cur_l_ff     <= '0;
         cur_r_ff     <= '0;
         nxt_l_ff     <= '0;
         nxt_r_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         count_ff     <= count_in;
         running_ff   <= running_in;
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         countdown_ff <= countdown_in;
         cur_l_ff     <= cur_l_in;
         cur_r_ff     <= cur_r_in;
         nxt_l_ff     <= nxt_l_in;
         nxt_r_ff     <= nxt_r_in;
      end
      ok_ff     <= ok_in;
      need_ff   <= need_in;
      dev_ff    <= dev_in;
      prod_l_ff <= prod_l_in;
      prod_r_ff <= prod_r_in;
   end

`ifndef NO_ASSERTIONS
   a_result_has_slot: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> out_free)
      else $error("result issued while output register is occupied");

   a_starved_has_frame: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.starved) |-> res.out_valid)
      else $error("starvation flagged without an output frame");

   a_write_only_idle: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_IDLE && !mem_re))
      else $error("frame store written during a pull");

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      (take && hold_op == OP_PUSH && count_ff != CW'(FIFO_DEPTH))
      |=> count_ff == $past(count_ff) + CW'(1))
      else $error("accepted push did not raise the fill count");

   a_starve_stops: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.starved) |=> !running_ff)
      else $error("playback still running after starvation");
`endif

endmodule

`default_nettype wire

@@ test/arl_checker.sv @@
// checker for the adaptive rate linear resampler: predicts each result and compares it
`timescale 1ns / 1ps

module arl_checker #(
   parameter int FIFO_DEPTH = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [31:0]  req_tdata,   // in_left, in_right
   input  logic         req_tuser,   // operation
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [95:0]  rsp_tdata,   // left_sample, right_sample, starved, push_dropped,
                                     // fill_level, ratio_step, zero pad
   input  logic         rsp_tuser,   // out_valid
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   input  logic         csr_pready,
   output int           fail_count,
   output int           pending,
   output int           frame_total,
   output int           starve_total,
   output int           drop_total
);
   import arl_pkg::*;

   localparam longint unsigned UNITY = 64'h1_0000_0000;

   cfg_type               cfg;
   logic [31:0]           fifo_mem [FIFO_DEPTH];
   int unsigned           wr_ptr;
   int unsigned           rd_ptr;
   int unsigned           fill;
   bit                    playing;
   longint unsigned       phase_acc;
   logic [STEP_W-1:0]     step_q;
   logic [15:0]           countdown;
   logic signed [15:0]    cur_l;
   logic signed [15:0]    cur_r;
   logic signed [15:0]    nxt_l;
   logic signed [15:0]    nxt_r;
   res_type               frames_due [$];
   int                    fails;

   assign fail_count = fails;

   function automatic void pop_frame(output logic signed [15:0] l, output logic signed [15:0] r);
      l = fifo_mem[rd_ptr][31:16];
      r = fifo_mem[rd_ptr][15:0];
      rd_ptr = (rd_ptr + 1) % FIFO_DEPTH;
      fill--;
   endfunction

   function automatic void retune_step();
      longint dev;
      longint lim;
      longint s;
      dev = longint'(cfg.ratio_gain) * (longint'(fill) - longint'(cfg.target_fill));
      lim = longint'(cfg.max_deviation);
      if (dev > lim) dev = lim;
      if (dev < -lim) dev = -lim;
      s = longint'(UNITY) + dev;
      if (s < 0) s = 0;
      if (s > 64'sh1_FFFF_FFFF) s = 64'sh1_FFFF_FFFF;
      step_q = s[STEP_W-1:0];
      countdown = cfg.update_interval;
   endfunction

   function automatic logic [OUT_W-1:0] blend(logic signed [15:0] c, logic signed [15:0] n);
      longint acc;
      logic [63:0] sh;
      acc = (longint'(c) <<< 32) + (longint'(n) - longint'(c)) * longint'(phase_acc);
      sh = acc >>> 24;
      return sh[OUT_W-1:0];
   endfunction

   function automatic res_type resample_item(logic op, logic [15:0] l, logic [15:0] r);
      res_type e;
      bit go;
      e = '0;
      if (op == OP_PUSH) begin
         if (fill >= FIFO_DEPTH) begin
            e.push_dropped = 1'b1;
         end else begin
            fifo_mem[wr_ptr] = {l, r};
            wr_ptr = (wr_ptr + 1) % FIFO_DEPTH;
            fill++;
         end
      end else begin
         go = playing;
         if (!go && fill >= cfg.start_fill && fill >= 2) begin
            pop_frame(cur_l, cur_r);
            pop_frame(nxt_l, nxt_r);
            playing = 1'b1;
            phase_acc = 0;
            retune_step();
            go = 1'b1;
         end
         if (go) begin
            if (countdown == 16'd0) retune_step();
            countdown = countdown - 16'd1;
            e.left_sample = blend(cur_l, nxt_l);
            e.right_sample = blend(cur_r, nxt_r);
            e.out_valid = 1'b1;
            phase_acc += step_q;
            while (phase_acc >= UNITY) begin
               phase_acc -= UNITY;
               cur_l = nxt_l;
               cur_r = nxt_r;
               if (fill == 0) begin
                  playing = 1'b0;
                  phase_acc = 0;
                  e.starved = 1'b1;
                  break;
               end
               pop_frame(nxt_l, nxt_r);
            end
         end
      end
      e.fill_level = fill[FILL_W-1:0];
      e.ratio_step = step_q;
      return e;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         fails++;
      end
   endtask

   always @(posedge clock) begin
      res_type want;
      res_type got;
      if (reset) begin
         cfg.target_fill <= TARGET_FILL_RST;
         cfg.start_fill <= START_FILL_RST;
         cfg.update_interval <= UPDATE_INTERVAL_RST;
         cfg.ratio_gain <= RATIO_GAIN_RST;
         cfg.max_deviation <= MAX_DEVIATION_RST;
         wr_ptr = 0;
         rd_ptr = 0;
         fill = 0;
         playing = 1'b0;
         phase_acc = 0;
         step_q = STEP_W'(UNITY);
         countdown = '0;
         cur_l = '0;
         cur_r = '0;
         nxt_l = '0;
         nxt_r = '0;
         frames_due.delete();
         fails = 0;
         frame_total <= 0;
         starve_total <= 0;
         drop_total <= 0;
         pending <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               REG_TARGET_FILL:     cfg.target_fill <= csr_pwdata[10:0];
               REG_START_FILL:      cfg.start_fill <= csr_pwdata[10:0];
               REG_UPDATE_INTERVAL: cfg.update_interval <= csr_pwdata[15:0];
               REG_RATIO_GAIN:      cfg.ratio_gain <= csr_pwdata[15:0];
               REG_MAX_DEVIATION:   cfg.max_deviation <= csr_pwdata[30:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            want = resample_item(req_tuser, req_tdata[15:0], req_tdata[31:16]);
            frames_due.push_back(want);
            if (want.out_valid) frame_total <= frame_total + 1;
            if (want.starved) starve_total <= starve_total + 1;
            if (want.push_dropped) drop_total <= drop_total + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.out_valid = rsp_tuser;
            got.left_sample = rsp_tdata[23:0];
            got.right_sample = rsp_tdata[47:24];
            got.starved = rsp_tdata[48];
            got.push_dropped = rsp_tdata[49];
            got.fill_level = rsp_tdata[60:50];
            got.ratio_step = rsp_tdata[93:61];
            if (frames_due.size() == 0) begin
               $display("%0t: unexpected result, expected none actual %0h", $time, got);
               fails++;
            end else begin
               want = frames_due.pop_front();
               check_field("out_valid", want.out_valid, got.out_valid);
               check_field("left_sample", want.left_sample, got.left_sample);
               check_field("right_sample", want.right_sample, got.right_sample);
               check_field("starved", want.starved, got.starved);
               check_field("push_dropped", want.push_dropped, got.push_dropped);
               check_field("fill_level", want.fill_level, got.fill_level);
               check_field("ratio_step", want.ratio_step, got.ratio_step);
            end
         end
         pending <= frames_due.size();
      end
   end

endmodule

@@ test/tb_top.sv @@
// testbench top for the adaptive rate linear resampler: stimulus, idling and verdict
`timescale 1ns / 1ps

module tb_top;
   import arl_pkg::*;

   localparam int SETTLE = 12;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [31:0]  req_tdata = '0;   // in_left, in_right
   logic         req_tuser = 1'b0; // operation
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [95:0]  rsp_tdata;        // left_sample, right_sample, starved, push_dropped,
                                   // fill_level, ratio_step, zero pad
   logic         rsp_tuser;        // out_valid
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [4:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   int           fail_count;
   int           pending;
   int           frame_total;
   int           starve_total;
   int           drop_total;

   bit           calm = 1'b0;
   bit           tx_choppy = 1'b1;
   bit           rx_choppy = 1'b1;
   int           stall_left = 0;
   int           push_total = 0;
   int           pull_total = 0;

   always #4 clock = ~clock;

   adaptive_rate_linear_resampler u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   arl_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_pready   (csr_pready),
      .fail_count   (fail_count),
      .pending      (pending),
      .frame_total  (frame_total),
      .starve_total (starve_total),
      .drop_total   (drop_total)
   );

   // receiver stalls in bursts, with quiet stretches in between
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!calm && rx_choppy && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 10);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
      if ($urandom_range(0, 199) == 0) rx_choppy <= !rx_choppy;
   end

   function automatic logic [15:0] pcm_sample();
      case ($urandom_range(0, 7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_frame(input logic op, input logic [15:0] l, input logic [15:0] r);
      int gap;
      if (!calm && tx_choppy && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 11);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {r, l};
      do @(posedge clock); while (!req_tready);
      if (op == OP_PUSH) push_total++;
      else pull_total++;
      if ($urandom_range(0, 99) == 0) tx_choppy = !tx_choppy;
   endtask

   task automatic push_frame();
      send_frame(OP_PUSH, pcm_sample(), pcm_sample());
   endtask

   task automatic pull_frame();
      send_frame(OP_PULL, 16'($urandom), 16'($urandom));
   endtask

   // hold off until every result is back and the pipeline has emptied
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_config(input logic [10:0] target, input logic [10:0] start,
                             input logic [15:0] interval, input logic [15:0] gain,
                             input logic [30:0] dev_limit);
      drain();
      csr_write(REG_TARGET_FILL, 32'(target));
      csr_write(REG_START_FILL, 32'(start));
      csr_write(REG_UPDATE_INTERVAL, 32'(interval));
      csr_write(REG_RATIO_GAIN, 32'(gain));
      csr_write(REG_MAX_DEVIATION, 32'(dev_limit));
   endtask

   task automatic run_phase(input int prefill, input int count, input int push_pct);
      int burst;
      repeat (prefill) push_frame();
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 29) == 0) begin
            burst = $urandom_range(2, 16);
            if ($urandom_range(0, 1) == 0) repeat (burst) push_frame();
            else repeat (burst) pull_frame();
         end else if ($urandom_range(0, 99) < push_pct) begin
            push_frame();
         end else begin
            pull_frame();
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // steep gain, wide clamp, one-pull update interval, lowest start level
      set_config(11'd0, 11'd2, 16'd1, 16'd65535, 31'h7FFF_FFFF);
      pull_frame();
      send_frame(OP_PUSH, 16'h7FFF, 16'h8000);
      send_frame(OP_PUSH, 16'h8000, 16'h7FFF);
      pull_frame();
      pull_frame();
      send_frame(OP_PUSH, 16'h0000, 16'hFFFF);
      send_frame(OP_PUSH, 16'hFFFF, 16'h0000);
      send_frame(OP_PUSH, 16'h7FFF, 16'h7FFF);
      send_frame(OP_PUSH, 16'h8000, 16'h8000);
      send_frame(OP_PUSH, 16'h5A5A, 16'hA5A5);
      repeat (7) pull_frame();
      send_frame(OP_PUSH, 16'h0001, 16'hFFFE);
      send_frame(OP_PUSH, 16'h8001, 16'h7FFE);
      repeat (3) pull_frame();

      set_config(TARGET_FILL_RST, START_FILL_RST, UPDATE_INTERVAL_RST, RATIO_GAIN_RST,
                 MAX_DEVIATION_RST);
      run_phase(260, 60, 50);
      drain();
      run_phase(0, 30, 45);

      // fill the store to the brim, then overfill; no rate correction
      set_config(11'd1024, 11'd1024, 16'd65535, 16'd0, 31'd0);
      run_phase(1030, 20, 50);

      set_config(11'd2047, 11'd2047, 16'd10, 16'd300, 31'd100000);
      run_phase(0, 20, 20);

      // zero update interval wraps the countdown
      set_config(11'd2047, 11'd0, 16'd0, 16'($urandom), 31'($urandom));
      run_phase(4, 80, 50);

      for (int p = 0; p < 3; p++) begin
         set_config(11'($urandom_range(0, 2047)), 11'($urandom_range(2, 64)),
                    ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 20)),
                    16'($urandom),
                    ($urandom_range(0, 1) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 24)));
         if (p == 2) calm = 1'b1;
         run_phase(20, 40, $urandom_range(40, 65));
      end

      drain();
      $display("covered %0d pushes and %0d pulls over eight register settings", push_total,
               pull_total);
      $display("%0d output frames, %0d starvation events, %0d dropped pushes", frame_total,
               starve_total, drop_total);
      if (fail_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("tb_top failed");
      $finish;
   end

endmodule
